// File: hw/rtl/dtes_pkg.sv
// Types, constants and calendar helpers for the date to epoch seconds core.
// No dependencies; used by date_to_epoch_seconds_core.
package dtes_pkg;

    localparam int unsigned YEAR_W      = 12;
    localparam int unsigned MONTH_W     = 4;
    localparam int unsigned DAY_W       = 5;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned MINUTE_W    = 6;
    localparam int unsigned SECOND_W    = 6;
    localparam int unsigned IN_DATA_W   = 40;
    localparam int unsigned OUT_DATA_W  = 32;

    localparam int unsigned YOFF_W      = 7;
    localparam int unsigned DOY_W       = 9;
    localparam int unsigned DAYS_W      = 16;
    localparam int unsigned TOD_W       = 17;
    localparam int unsigned MS_W        = 12;

    localparam logic [YEAR_W-1:0]   YEAR_FIRST     = 12'd2000;
    localparam logic [YEAR_W-1:0]   YEAR_LAST      = 12'd2099;
    localparam logic [DAYS_W-1:0]   DAYS_TO_2000   = 16'd10957;
    localparam logic [16:0]         SECONDS_PER_DAY = 17'd86400;
    localparam logic [11:0]         SECONDS_PER_HOUR = 12'd3600;
    localparam logic [5:0]          SECONDS_PER_MINUTE = 6'd60;
    localparam logic [8:0]          DAYS_PER_YEAR  = 9'd365;
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY  = 5'd24;
    localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;

    localparam logic [MONTH_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0]  MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0]  MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0]  MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0]  MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0]  MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0]  MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0]  MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0]  MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0]  MONTH_DEC = 4'd12;

    localparam logic [31:0] EPOCH_MAX = 32'd4102444799;

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            [MONTH_JAN:MONTH_DEC]:                     len = 5'd31;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] days;
        case (m)
            MONTH_FEB: days = 9'd31;
            MONTH_MAR: days = 9'd59;
            MONTH_APR: days = 9'd90;
            MONTH_MAY: days = 9'd120;
            MONTH_JUN: days = 9'd151;
            MONTH_JUL: days = 9'd181;
            MONTH_AUG: days = 9'd212;
            MONTH_SEP: days = 9'd243;
            MONTH_OCT: days = 9'd273;
            MONTH_NOV: days = 9'd304;
            MONTH_DEC: days = 9'd334;
            default:   days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// File: hw/rtl/date_to_epoch_seconds_core.sv
// Calendar date and time to Unix epoch seconds, four-stage pipeline.
// Depends on dtes_pkg for field widths, calendar constants and month tables.
//
// Each transfer on the slave side carries one date and time (years 2000 to 2099);
// each transfer on the master side carries one result, in the same order. The
// block accepts one transfer per cycle when the master side is not stalled; each
// result passes through the four register stages (checks and day of year, day
// count, multiply by 86400, add and select). Every stage holds its own valid
// bit, so bubbles close up under back pressure. m_tuser is high when the date
// and time are valid; otherwise m_tdata is zero.
module date_to_epoch_seconds_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // year_value[11:0], month_value[15:12], day_value[20:16], hour_value[25:21],
    // minute_value[31:26], second_value[37:32], zero[39:38]
    input  logic [dtes_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // epoch_seconds[31:0]
    output logic [dtes_pkg::OUT_DATA_W-1:0]  m_tdata,
    // date_ok[0]
    output logic                             m_tuser
);

    localparam int unsigned TOD_W = dtes_pkg::TOD_W;
    localparam int unsigned MS_W  = dtes_pkg::MS_W;

    logic [dtes_pkg::YEAR_W-1:0]   year_in;
    logic [dtes_pkg::MONTH_W-1:0]  month_in;
    logic [dtes_pkg::DAY_W-1:0]    day_in;
    logic [dtes_pkg::HOUR_W-1:0]   hour_in;
    logic [dtes_pkg::MINUTE_W-1:0] minute_in;
    logic [dtes_pkg::SECOND_W-1:0] second_in;

    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [dtes_pkg::YEAR_W-1:0]   year_off;
    logic                          leap;
    logic                          s1_ok_next, s1_ok_reg;
    logic [dtes_pkg::YOFF_W-1:0]   s1_yoff_next, s1_yoff_reg;
    logic [dtes_pkg::DOY_W-1:0]    s1_doy_next, s1_doy_reg;
    logic [dtes_pkg::TOD_W-1:0]    s1_hsec_next, s1_hsec_reg;
    logic [dtes_pkg::MS_W-1:0]     s1_msec_next, s1_msec_reg;

    logic                          s2_ok_reg;
    logic [dtes_pkg::DAYS_W-1:0]   s2_days_next, s2_days_reg;
    logic [dtes_pkg::TOD_W-1:0]    s2_tod_next, s2_tod_reg;

    logic                          s3_ok_reg;
    logic [31:0]                   s3_prod_next, s3_prod_reg;
    logic [dtes_pkg::TOD_W-1:0]    s3_tod_reg;

    logic                          s4_ok_reg;
    logic [31:0]                   s4_secs_next, s4_secs_reg;

    assign year_in   = s_tdata[11:0];
    assign month_in  = s_tdata[15:12];
    assign day_in    = s_tdata[20:16];
    assign hour_in   = s_tdata[25:21];
    assign minute_in = s_tdata[31:26];
    assign second_in = s_tdata[37:32];

    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // Stage 1: range checks, day of year, time of day parts
    always_comb
    begin
        year_off     = year_in - dtes_pkg::YEAR_FIRST;
        leap         = (year_off[1:0] == 2'd0);
        s1_ok_next   = (year_in >= dtes_pkg::YEAR_FIRST) && (year_in <= dtes_pkg::YEAR_LAST)
                    && (day_in != '0)
                    && (day_in <= dtes_pkg::month_length(month_in, leap))
                    && (hour_in < dtes_pkg::HOURS_PER_DAY)
                    && (minute_in < dtes_pkg::MINUTES_PER_HOUR)
                    && (second_in < dtes_pkg::MINUTES_PER_HOUR);
        s1_yoff_next = year_off[dtes_pkg::YOFF_W-1:0];
        s1_doy_next  = dtes_pkg::days_before_month(month_in)
                     + {8'd0, (leap && (month_in > dtes_pkg::MONTH_FEB))}
                     + {4'd0, day_in} - 9'd1;
        s1_hsec_next = TOD_W'(hour_in * dtes_pkg::SECONDS_PER_HOUR);
        s1_msec_next = MS_W'(minute_in * dtes_pkg::SECONDS_PER_MINUTE)
                     + {6'd0, second_in};
    end

    // Stage 2: days since 1970 and seconds of the day
    always_comb
    begin
        s2_days_next = dtes_pkg::DAYS_TO_2000
                     + 16'(s1_yoff_reg * dtes_pkg::DAYS_PER_YEAR)
                     + {11'd0, 5'((8'(s1_yoff_reg) + 8'd3) >> 2)}
                     + {7'd0, s1_doy_reg};
        s2_tod_next  = s1_hsec_reg + {5'd0, s1_msec_reg};
    end

    // Stage 3: scale days to seconds
    assign s3_prod_next = 32'(s2_days_reg * dtes_pkg::SECONDS_PER_DAY);

    // Stage 4: add time of day, zero on failed checks
    assign s4_secs_next = s3_ok_reg ? (s3_prod_reg + {15'd0, s3_tod_reg}) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_ok_reg   <= s1_ok_next;
            s1_yoff_reg <= s1_yoff_next;
            s1_doy_reg  <= s1_doy_next;
            s1_hsec_reg <= s1_hsec_next;
            s1_msec_reg <= s1_msec_next;
        end
        if (adv2)
        begin
            s2_ok_reg   <= s1_ok_reg;
            s2_days_reg <= s2_days_next;
            s2_tod_reg  <= s2_tod_next;
        end
        if (adv3)
        begin
            s3_ok_reg   <= s2_ok_reg;
            s3_prod_reg <= s3_prod_next;
            s3_tod_reg  <= s2_tod_reg;
        end
        if (adv4)
        begin
            s4_ok_reg   <= s3_ok_reg;
            s4_secs_reg <= s4_secs_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = s4_secs_reg;
    assign m_tuser  = s4_ok_reg;

    a_bad_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("invalid date with nonzero seconds");

    a_secs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata <= dtes_pkg::EPOCH_MAX))
        else $error("epoch seconds beyond year 2099");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready))
        else $error("input blocked with a free stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !v4_reg) |=> v4_reg)
        else $error("stage 3 result did not advance into an empty output stage");

endmodule
